// ----- rtl/awc_pkg.sv -----
// Shared types and constants for the associative word cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package awc_pkg;

	localparam int DATA_W          = 32;
	localparam int ADDR_W          = 32;
	localparam int WORDS_PER_LINE  = 8;
	localparam int WORD_OFF_W      = $clog2(WORDS_PER_LINE);
	localparam int TAG_W           = ADDR_W - WORD_OFF_W - 2;
	localparam int DEF_CACHE_LINES = 64;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_FILL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		RK_READ          = 3'd0,
		RK_FILL_REQ      = 3'd1,
		RK_WRITE_THROUGH = 3'd2,
		RK_MISALIGNED    = 3'd3,
		RK_SEQUENCE      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_READ  = 2'd1,
		PEND_WRITE = 2'd2
	} pend_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;
		logic  flush;
		logic  fill_wr;
		logic  fill_done;
		logic  hit_access;
		logic  alloc;
		logic  emit;
		kind_t kind;
		logic  hit;
	} awc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic pend_none;
		logic pend_write;
		logic misaligned;
		logic fill_last;
		logic hit;
	} awc_stat_t;

endpackage

// ----- rtl/awc_ctrl.sv -----
// Controller state machine of the associative word cache.
// Depends on awc_pkg for the command and status structs.
module awc_ctrl
	import awc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  awc_stat_t stat,
	output awc_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_LOOKUP = 5'b00100,
		S_FINISH = 5'b01000,
		S_RDATA  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   rd_hit_q, rd_hit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_hit_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_hit_q <= rd_hit_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_hit_d = rd_hit_q;
		cmd      = '0;
		cmd.kind = RK_READ;
		busy     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				unique case (stat.op) inside
					OP_FLUSH: begin
						cmd.flush = 1'b1;
					end
					OP_FILL: begin
						if (stat.pend_none) begin
							cmd.emit = 1'b1;
							cmd.kind = RK_SEQUENCE;
						end else begin
							cmd.fill_wr = 1'b1;
							if (stat.fill_last) begin
								state_d = S_FINISH;
							end
						end
					end
					OP_READ, OP_WRITE: begin
						if (!stat.pend_none) begin
							cmd.emit = 1'b1;
							cmd.kind = RK_SEQUENCE;
						end else if (stat.misaligned) begin
							cmd.emit = 1'b1;
							cmd.kind = RK_MISALIGNED;
						end else begin
							state_d = S_LOOKUP;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_LOOKUP: begin
				state_d = S_IDLE;
				if (stat.hit) begin
					cmd.hit_access = 1'b1;
					if (stat.op == OP_WRITE) begin
						cmd.emit = 1'b1;
						cmd.kind = RK_WRITE_THROUGH;
						cmd.hit  = 1'b1;
					end else begin
						rd_hit_d = 1'b1;
						state_d  = S_RDATA;
					end
				end else begin
					cmd.alloc = 1'b1;
					cmd.emit  = 1'b1;
					cmd.kind  = RK_FILL_REQ;
				end
			end
			S_FINISH: begin
				cmd.fill_done = 1'b1;
				if (stat.pend_write) begin
					cmd.emit = 1'b1;
					cmd.kind = RK_WRITE_THROUGH;
					state_d  = S_IDLE;
				end else begin
					rd_hit_d = 1'b0;
					state_d  = S_RDATA;
				end
			end
			S_RDATA: begin
				cmd.emit = 1'b1;
				cmd.kind = RK_READ;
				cmd.hit  = rd_hit_q;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A line is only claimed when no fill is outstanding.
	a_alloc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> stat.pend_none)
		else $error("line allocated while a fill is pending");

	// Finishing a line always follows the write of its last fill beat.
	a_finish_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_done |-> $past(cmd.fill_wr))
		else $error("line finished without a last fill beat");
`endif

endmodule

// ----- rtl/awc_dpath.sv -----
// Datapath of the associative word cache: tag store and match, line data RAM,
// pending-miss registers and the result register. Depends on awc_pkg.
module awc_dpath
	import awc_pkg::*;
#(
	parameter int CACHE_LINES = DEF_CACHE_LINES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] word_addr,
	input  logic [DATA_W-1:0] write_data,
	input  logic [DATA_W-1:0] fill_word,
	input  awc_cmd_t          cmd,
	output awc_stat_t         stat,
	output logic              done,
	output logic [2:0]        result_kind,
	output logic [ADDR_W-1:0] addr_out,
	output logic [DATA_W-1:0] data_out,
	output logic              was_hit
);

	localparam int LineW    = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
	localparam int RamW     = LineW + WORD_OFF_W;
	localparam int RamDepth = CACHE_LINES * WORDS_PER_LINE;

	op_t                   op_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [DATA_W-1:0]     wdata_q;
	logic [DATA_W-1:0]     fword_q;

	logic [CACHE_LINES-1:0] valid_q;
	logic [TAG_W-1:0]       tag_q [CACHE_LINES];
	logic [CACHE_LINES-1:0] hit_vec_s1;
	logic [LineW-1:0]       hit_idx;
	logic [LineW-1:0]       victim_q;
	logic [LineW-1:0]       victim_next;

	pend_t                 pend_op_q;
	logic [ADDR_W-1:0]     pend_addr_q;
	logic [DATA_W-1:0]     pend_data_q;
	logic [WORD_OFF_W-1:0] fill_idx_q;

	logic [DATA_W-1:0] mem [RamDepth];
	logic [RamW-1:0]   ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_we;
	logic [DATA_W-1:0] ram_rdata_q;

	logic              done_q;
	kind_t             kind_q;
	logic [ADDR_W-1:0] addr_out_q;
	logic [DATA_W-1:0] data_out_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			addr_q  <= word_addr;
			wdata_q <= write_data;
			fword_q <= fill_word;
		end
	end

	// Fully associative match against every valid line, registered for the
	// lookup cycle. Valid tags are unique, so at most one bit is set.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CACHE_LINES; i++) begin
			hit_vec_s1[i] <= valid_q[i] && (tag_q[i] == addr_q[ADDR_W-1:WORD_OFF_W+2]);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CACHE_LINES; i++) begin
			if (hit_vec_s1[i]) begin
				hit_idx = hit_idx | LineW'(i);
			end
		end
	end

	assign victim_next = (victim_q == LineW'(CACHE_LINES - 1)) ? '0 : victim_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			victim_q   <= '0;
			pend_op_q  <= PEND_NONE;
			fill_idx_q <= '0;
		end else if (cmd.flush) begin
			valid_q    <= '0;
			victim_q   <= '0;
			pend_op_q  <= PEND_NONE;
			fill_idx_q <= '0;
		end else if (cmd.alloc) begin
			valid_q[victim_q] <= 1'b0;
			pend_op_q         <= (op_q == OP_WRITE) ? PEND_WRITE : PEND_READ;
			fill_idx_q        <= '0;
		end else if (cmd.fill_wr) begin
			fill_idx_q <= fill_idx_q + 1'b1;
		end else if (cmd.fill_done) begin
			valid_q[victim_q] <= 1'b1;
			victim_q          <= victim_next;
			pend_op_q         <= PEND_NONE;
			fill_idx_q        <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			pend_addr_q <= addr_q;
			pend_data_q <= (op_q == OP_WRITE) ? wdata_q : '0;
		end
		if (cmd.fill_done) begin
			tag_q[victim_q] <= pend_addr_q[ADDR_W-1:WORD_OFF_W+2];
		end
	end

	always_comb begin
		ram_addr  = {hit_idx, addr_q[WORD_OFF_W+1:2]};
		ram_wdata = wdata_q;
		ram_we    = 1'b0;
		if (cmd.fill_wr) begin
			ram_addr  = {victim_q, fill_idx_q};
			ram_wdata = fword_q;
			ram_we    = 1'b1;
		end else if (cmd.fill_done) begin
			ram_addr  = {victim_q, pend_addr_q[WORD_OFF_W+1:2]};
			ram_wdata = pend_data_q;
			ram_we    = (pend_op_q == PEND_WRITE);
		end else if (cmd.hit_access) begin
			ram_we = (op_q == OP_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			mem[ram_addr] <= ram_wdata;
		end
		ram_rdata_q <= mem[ram_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	// Hits report the access itself; a finished miss reports the pending one.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			hit_q  <= cmd.hit;
			case (cmd.kind)
				RK_READ: begin
					addr_out_q <= cmd.hit ? addr_q : pend_addr_q;
					data_out_q <= ram_rdata_q;
				end
				RK_WRITE_THROUGH: begin
					addr_out_q <= cmd.hit ? addr_q : pend_addr_q;
					data_out_q <= cmd.hit ? wdata_q : pend_data_q;
				end
				RK_FILL_REQ: begin
					addr_out_q <= {addr_q[ADDR_W-1:WORD_OFF_W+2], (WORD_OFF_W + 2)'(0)};
					data_out_q <= '0;
				end
				RK_MISALIGNED: begin
					addr_out_q <= addr_q;
					data_out_q <= '0;
				end
				default: begin
					addr_out_q <= '0;
					data_out_q <= '0;
				end
			endcase
		end
	end

	assign stat.op         = op_q;
	assign stat.pend_none  = (pend_op_q == PEND_NONE);
	assign stat.pend_write = (pend_op_q == PEND_WRITE);
	assign stat.misaligned = (addr_q[1:0] != 2'b00);
	assign stat.fill_last  = (fill_idx_q == WORD_OFF_W'(WORDS_PER_LINE - 1));
	assign stat.hit        = |hit_vec_s1;

	assign done        = done_q;
	assign result_kind = kind_q;
	assign addr_out    = addr_out_q;
	assign data_out    = data_out_q;
	assign was_hit     = hit_q;

`ifndef SYNTHESIS
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec_s1))
		else $error("address matches more than one line");

	// The line being filled stays invalid until its last beat.
	a_victim_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_op_q != PEND_NONE) |-> !valid_q[victim_q])
		else $error("claimed line valid during its fill");

	a_fill_idx_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_idx_q != '0) |-> (pend_op_q != PEND_NONE))
		else $error("fill progress without a pending miss");
`endif

endmodule

// ----- rtl/assoc_word_cache_fifo_core.sv -----
// Fully associative write-through word cache with FIFO replacement.
//
// One command beat is taken at a rising edge with start high and busy low:
// opcode, word_addr, write_data and fill_word are sampled there. A result
// beat is shown for one cycle with done high and cannot be held off.
// States passed after the accept edge; the result comes from the last one:
//   errors: DECODE; flush and non-final fill beats: DECODE, with no result
//   write hit, fill request: DECODE, LOOKUP; write-through after a miss:
//   DECODE, FINISH; read hit: DECODE, LOOKUP, RDATA; read after the last
//   fill beat: DECODE, FINISH, RDATA
// busy is low again at the edge that shows the result, so the next command
// can be accepted there. The spacing between commands is set by the registered
// tag match and the single-port line RAM with registered read.
// A miss returns a fill request at once; the line's words then arrive as
// fill commands in ascending order, and the last one produces the answer.
// Reset clears all line valid bits, the replacement pointer and any pending
// miss; it takes effect at once and needs no clearing pass.
// Depends on awc_pkg, awc_ctrl and awc_dpath.
module assoc_word_cache_fifo_core
	import awc_pkg::*;
#(
	parameter int CACHE_LINES = DEF_CACHE_LINES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] word_addr,
	input  logic [DATA_W-1:0] write_data,
	input  logic [DATA_W-1:0] fill_word,
	output logic              done,
	output logic [2:0]        result_kind,
	output logic [ADDR_W-1:0] addr_out,
	output logic [DATA_W-1:0] data_out,
	output logic              was_hit
);

	awc_cmd_t  cmd;
	awc_stat_t stat;

	awc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	awc_dpath #(
		.CACHE_LINES (CACHE_LINES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.word_addr   (word_addr),
		.write_data  (write_data),
		.fill_word   (fill_word),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.result_kind (result_kind),
		.addr_out    (addr_out),
		.data_out    (data_out),
		.was_hit     (was_hit)
	);

endmodule
